// ----- hw/rtl/msk_pkg.sv -----
// Shared types and constants for the marked stack engine.
// Used by msk_ctrl, msk_dpath and marked_stack_engine; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package msk_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = ADDR_W + 1;
    localparam int WORD_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int MARK_W  = 10;
    localparam int OFF_W   = 11;
    localparam int SLOT_W  = 11;
    localparam int CAP_W   = 11;
    localparam int MOUT_W  = 11;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FN_PUSH     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_POP      = 3'd1;
    localparam logic [FUNC_W-1:0] FN_PEEK     = 3'd2;
    localparam logic [FUNC_W-1:0] FN_GET      = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CHANGE   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_GRAB     = 3'd5;
    localparam logic [FUNC_W-1:0] FN_CLR_MARK = 3'd6;
    localparam logic [FUNC_W-1:0] FN_CLEAR    = 3'd7;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] ST_RANGE    = 2'd3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(DEPTH);

    typedef struct packed {
        logic accept;
        logic load_out;
        logic clr_en;
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- hw/rtl/msk_ctrl.sv -----
// Controller state machine for the marked stack engine: clearing sweep, accept, result load.
// Depends on msk_pkg; drives the command struct of msk_dpath.
`timescale 1ns / 1ps
`default_nettype none

module msk_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    input  wire msk_pkg::t_dp_status i_dp_status,
    output msk_pkg::t_ctrl_cmd      o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        o_cmd          = '0;
        n_state        = r_state;
        n_out_valid    = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_dp_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_accept_to_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_READ))
        else $error("accepted transfer did not move to the read state");

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result valid during the clearing sweep");

    a_read_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && !o_cmd.load_out) |=> (r_state == S_READ && r_out_valid))
        else $error("pending result dropped while output was stalled");

endmodule

`default_nettype wire

// ----- hw/rtl/msk_dpath.sv -----
// Datapath for the marked stack engine: word store, fill pointer, capacity and result registers.
// Depends on msk_pkg; controlled by msk_ctrl through the command struct.
`timescale 1ns / 1ps
`default_nettype none

module msk_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire msk_pkg::t_ctrl_cmd            i_cmd,
    output msk_pkg::t_dp_status                o_dp_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [msk_pkg::CAP_W-1:0]     i_cfg_capacity,
    input  wire logic [msk_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [msk_pkg::WORD_W-1:0]    i_data_in,
    input  wire logic [msk_pkg::MARK_W-1:0]    i_mark_in,
    input  wire logic signed [msk_pkg::OFF_W-1:0] i_offset,
    input  wire logic [msk_pkg::SLOT_W-1:0]    i_slot_count,
    output logic [msk_pkg::WORD_W-1:0]         o_data_out,
    output logic signed [msk_pkg::MOUT_W-1:0]  o_mark_out,
    output logic                               o_empty_res,
    output logic                               o_full_res,
    output logic [msk_pkg::STAT_W-1:0]         o_status
);

    logic [msk_pkg::WORD_W-1:0] r_mem [msk_pkg::DEPTH];
    logic [msk_pkg::WORD_W-1:0] r_rd_data;
    logic [msk_pkg::ADDR_W-1:0] r_clr_idx;
    logic [msk_pkg::FILL_W-1:0] r_fill;
    logic [msk_pkg::FILL_W-1:0] n_fill;
    logic [msk_pkg::CAP_W-1:0]  r_cap;

    logic [msk_pkg::MOUT_W-1:0] r_res_mark;
    logic [msk_pkg::MOUT_W-1:0] n_res_mark;
    logic [msk_pkg::STAT_W-1:0] r_res_status;
    logic [msk_pkg::STAT_W-1:0] n_res_status;
    logic                       r_res_rd;
    logic                       n_res_rd;
    logic                       r_res_empty;
    logic                       r_res_full;

    logic [msk_pkg::WORD_W-1:0] r_data_out;
    logic [msk_pkg::MOUT_W-1:0] r_mark_out;
    logic                       r_empty;
    logic                       r_full;
    logic [msk_pkg::STAT_W-1:0] r_status;

    logic [msk_pkg::CAP_W-1:0]  cap_eff;
    logic [msk_pkg::FILL_W:0]   pos;
    logic [msk_pkg::FILL_W:0]   grab_sum;
    logic [msk_pkg::FILL_W-1:0] fill_m1;
    logic                       idx_ok;
    logic                       wr_en;
    logic [msk_pkg::ADDR_W-1:0] wr_addr;
    logic [msk_pkg::ADDR_W-1:0] rd_addr;

    assign cap_eff  = (r_cap > msk_pkg::CAP_W'(msk_pkg::DEPTH)) ?
                      msk_pkg::CAP_W'(msk_pkg::DEPTH) : r_cap;
    assign pos      = {2'b00, i_mark_in} + {i_offset[msk_pkg::OFF_W-1], i_offset};
    assign grab_sum = {1'b0, r_fill} + {1'b0, i_slot_count};
    assign fill_m1  = r_fill - msk_pkg::FILL_W'(1);
    assign idx_ok   = ({1'b0, i_mark_in} < r_fill) && !pos[msk_pkg::FILL_W]
                      && (pos[msk_pkg::FILL_W-1:0] < r_fill);

    always_comb begin
        n_fill       = r_fill;
        n_res_mark   = '0;
        n_res_status = msk_pkg::ST_OK;
        n_res_rd     = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = r_fill[msk_pkg::ADDR_W-1:0];
        rd_addr      = fill_m1[msk_pkg::ADDR_W-1:0];
        unique case (i_func)
            msk_pkg::FN_PUSH: begin
                if (r_fill >= cap_eff) begin
                    n_res_status = msk_pkg::ST_OVERFLOW;
                end else begin
                    n_res_mark = r_fill;
                    wr_en      = 1'b1;
                    n_fill     = r_fill + msk_pkg::FILL_W'(1);
                end
            end
            msk_pkg::FN_POP: begin
                if (r_fill == '0) begin
                    n_res_status = msk_pkg::ST_EMPTY;
                end else begin
                    n_res_rd = 1'b1;
                    n_fill   = fill_m1;
                end
            end
            msk_pkg::FN_PEEK: begin
                if (r_fill == '0) begin
                    n_res_status = msk_pkg::ST_EMPTY;
                end else begin
                    n_res_rd = 1'b1;
                end
            end
            msk_pkg::FN_GET: begin
                rd_addr = pos[msk_pkg::ADDR_W-1:0];
                if (idx_ok) begin
                    n_res_rd = 1'b1;
                end else begin
                    n_res_status = msk_pkg::ST_RANGE;
                end
            end
            msk_pkg::FN_CHANGE: begin
                wr_addr = pos[msk_pkg::ADDR_W-1:0];
                if (idx_ok) begin
                    wr_en = 1'b1;
                end else begin
                    n_res_status = msk_pkg::ST_RANGE;
                end
            end
            msk_pkg::FN_GRAB: begin
                if (grab_sum >= {1'b0, cap_eff}) begin
                    n_res_status = msk_pkg::ST_OVERFLOW;
                end else begin
                    n_fill     = grab_sum[msk_pkg::FILL_W-1:0];
                    n_res_mark = grab_sum[msk_pkg::MOUT_W-1:0] - msk_pkg::MOUT_W'(1);
                end
            end
            msk_pkg::FN_CLR_MARK: begin
                if ({1'b0, i_mark_in} >= r_fill) begin
                    n_res_status = msk_pkg::ST_RANGE;
                end else begin
                    n_fill = {1'b0, i_mark_in};
                end
            end
            msk_pkg::FN_CLEAR: begin
                n_fill = '0;
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            r_mem[r_clr_idx] <= '0;
        end else if (i_cmd.accept && wr_en) begin
            r_mem[wr_addr] <= i_data_in;
        end
        if (i_cmd.accept) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_fill    <= '0;
            r_cap     <= msk_pkg::CAP_RESET;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr_idx <= r_clr_idx + msk_pkg::ADDR_W'(1);
            end
            if (i_cmd.accept) begin
                r_fill <= n_fill;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_res_mark   <= n_res_mark;
            r_res_status <= n_res_status;
            r_res_rd     <= n_res_rd;
            r_res_empty  <= (n_fill == '0);
            r_res_full   <= (n_fill >= cap_eff);
        end
        if (i_cmd.load_out) begin
            r_data_out <= r_res_rd ? r_rd_data : '0;
            r_mark_out <= r_res_mark;
            r_empty    <= r_res_empty;
            r_full     <= r_res_full;
            r_status   <= r_res_status;
        end
    end

    assign o_dp_status.clr_last = &r_clr_idx;
    assign o_data_out           = r_data_out;
    assign o_mark_out           = $signed(r_mark_out);
    assign o_empty_res          = r_empty;
    assign o_full_res           = r_full;
    assign o_status             = r_status;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= msk_pkg::FILL_W'(msk_pkg::DEPTH))
        else $error("fill pointer beyond the store depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && i_func == msk_pkg::FN_PUSH && n_res_status == msk_pkg::ST_OK)
        |=> (r_fill == $past(r_fill) + msk_pkg::FILL_W'(1)))
        else $error("successful push did not advance the fill pointer");

    a_error_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.accept && n_res_status != msk_pkg::ST_OK) |=> $stable(r_fill))
        else $error("failed operation changed the fill pointer");

endmodule

`default_nettype wire

// ----- hw/rtl/marked_stack_engine.sv -----
// Top level of the marked stack engine: joins the controller and the datapath.
// Depends on msk_pkg, msk_ctrl and msk_dpath.
`timescale 1ns / 1ps
`default_nettype none

// A LIFO stack of 1024 words of 32 bits with push, pop, peek, indexed get and
// change, grab, clear to mark and clear; every operation returns one result
// with the empty and full flags and a status code. After reset the store is
// cleared one entry per cycle, so no operation is accepted until the sweep has
// cleared every entry; the capacity register takes a write in any cycle and
// should be written only while no operation is in flight. The result of an
// operation is captured at acceptance, with the registered read of the store,
// and moved to the output registers in the read state once they are free.
// The next operation is accepted only after that move, while that result may
// still wait on the output; its own result is held until that one is taken.
module marked_stack_engine (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [msk_pkg::FUNC_W-1:0]        i_func,
    input  wire logic [msk_pkg::WORD_W-1:0]        i_data_in,
    input  wire logic [msk_pkg::MARK_W-1:0]        i_mark_in,
    input  wire logic signed [msk_pkg::OFF_W-1:0]  i_offset,
    input  wire logic [msk_pkg::SLOT_W-1:0]        i_slot_count,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [msk_pkg::WORD_W-1:0]             o_data_out,
    output logic signed [msk_pkg::MOUT_W-1:0]      o_mark_out,
    output logic                                   o_empty_res,
    output logic                                   o_full_res,
    output logic [msk_pkg::STAT_W-1:0]             o_status,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [msk_pkg::CAP_W-1:0]         i_cfg_capacity
);

    msk_pkg::t_ctrl_cmd  cmd;
    msk_pkg::t_dp_status dp_status;

    assign o_cfg_ready = 1'b1;

    msk_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    msk_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_dp_status    (dp_status),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_capacity (i_cfg_capacity),
        .i_func         (i_func),
        .i_data_in      (i_data_in),
        .i_mark_in      (i_mark_in),
        .i_offset       (i_offset),
        .i_slot_count   (i_slot_count),
        .o_data_out     (o_data_out),
        .o_mark_out     (o_mark_out),
        .o_empty_res    (o_empty_res),
        .o_full_res     (o_full_res),
        .o_status       (o_status)
    );

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for marked_stack_engine: directed and random stack operations,
// with results checked against a scoreboard that models the stack and the capacity register.
// Depends on msk_pkg and the marked_stack_engine RTL.
`timescale 1ns / 1ps

module tb;

    localparam int IDLE_LIMIT = 3000;

    typedef struct packed {
        logic [msk_pkg::WORD_W-1:0]        data;
        logic signed [msk_pkg::MOUT_W-1:0] mark;
        logic                              empty;
        logic                              full;
        logic [msk_pkg::STAT_W-1:0]        status;
    } t_stack_result;

    class stack_scoreboard;
        logic [msk_pkg::WORD_W-1:0] words [msk_pkg::DEPTH];
        int unsigned                fill;
        int unsigned                cap_reg;
        t_stack_result              results_due [$];
        int unsigned                errors;

        function void reset_state();
            foreach (words[i]) words[i] = '0;
            fill = 0;
            cap_reg = msk_pkg::CAP_RESET;
            errors = 0;
            results_due.delete();
        endfunction

        function void set_capacity(logic [msk_pkg::CAP_W-1:0] value);
            cap_reg = value;
        endfunction

        function int unsigned eff_capacity();
            return (cap_reg > msk_pkg::DEPTH) ? msk_pkg::DEPTH : cap_reg;
        endfunction

        function void note_op(logic [msk_pkg::FUNC_W-1:0] fn,
                              logic [msk_pkg::WORD_W-1:0] data,
                              logic [msk_pkg::MARK_W-1:0] mark,
                              logic signed [msk_pkg::OFF_W-1:0] off,
                              logic [msk_pkg::SLOT_W-1:0] slots);
            t_stack_result r;
            int unsigned   eff;
            int            pos;
            eff = eff_capacity();
            r = '0;
            r.status = msk_pkg::ST_OK;
            case (fn)
                msk_pkg::FN_PUSH: begin
                    if (fill >= eff) begin
                        r.status = msk_pkg::ST_OVERFLOW;
                    end else begin
                        r.mark = msk_pkg::MOUT_W'(fill);
                        words[fill] = data;
                        fill++;
                    end
                end
                msk_pkg::FN_POP: begin
                    if (fill == 0) begin
                        r.status = msk_pkg::ST_EMPTY;
                    end else begin
                        fill--;
                        r.data = words[fill];
                    end
                end
                msk_pkg::FN_PEEK: begin
                    if (fill == 0) r.status = msk_pkg::ST_EMPTY;
                    else r.data = words[fill - 1];
                end
                msk_pkg::FN_GET, msk_pkg::FN_CHANGE: begin
                    pos = int'(mark) + int'(off);
                    if (mark >= fill || pos < 0 || pos >= int'(fill)) begin
                        r.status = msk_pkg::ST_RANGE;
                    end else if (fn == msk_pkg::FN_GET) begin
                        r.data = words[pos];
                    end else begin
                        words[pos] = data;
                    end
                end
                msk_pkg::FN_GRAB: begin
                    if (fill + slots >= eff) begin
                        r.status = msk_pkg::ST_OVERFLOW;
                    end else begin
                        fill += slots;
                        r.mark = msk_pkg::MOUT_W'(int'(fill) - 1);
                    end
                end
                msk_pkg::FN_CLR_MARK: begin
                    if (mark >= fill) r.status = msk_pkg::ST_RANGE;
                    else fill = mark;
                end
                msk_pkg::FN_CLEAR: begin
                    fill = 0;
                end
            endcase
            r.empty = (fill == 0);
            r.full = (fill >= eff);
            results_due.push_back(r);
        endfunction

        function void check_result(t_stack_result act);
            t_stack_result exp;
            if (results_due.size() == 0) begin
                $error("result transfer with no operation pending");
                errors++;
                return;
            end
            exp = results_due.pop_front();
            if (act.data !== exp.data) begin
                $error("data_out: expected %h actual %h", exp.data, act.data);
                errors++;
            end
            if (act.mark !== exp.mark) begin
                $error("mark_out: expected %0d actual %0d", exp.mark, act.mark);
                errors++;
            end
            if (act.empty !== exp.empty) begin
                $error("empty_res: expected %b actual %b", exp.empty, act.empty);
                errors++;
            end
            if (act.full !== exp.full) begin
                $error("full_res: expected %b actual %b", exp.full, act.full);
                errors++;
            end
            if (act.status !== exp.status) begin
                $error("status: expected %0d actual %0d", exp.status, act.status);
                errors++;
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_in_valid = 1'b0;
    logic                              o_in_ready;
    logic [msk_pkg::FUNC_W-1:0]        i_func = msk_pkg::FN_PUSH;
    logic [msk_pkg::WORD_W-1:0]        i_data_in = '0;
    logic [msk_pkg::MARK_W-1:0]        i_mark_in = '0;
    logic signed [msk_pkg::OFF_W-1:0]  i_offset = '0;
    logic [msk_pkg::SLOT_W-1:0]        i_slot_count = '0;
    logic                              o_out_valid;
    logic                              i_out_ready = 1'b0;
    logic [msk_pkg::WORD_W-1:0]        o_data_out;
    logic signed [msk_pkg::MOUT_W-1:0] o_mark_out;
    logic                              o_empty_res;
    logic                              o_full_res;
    logic [msk_pkg::STAT_W-1:0]        o_status;
    logic                              i_cfg_valid = 1'b0;
    logic                              o_cfg_ready;
    logic [msk_pkg::CAP_W-1:0]         i_cfg_capacity = msk_pkg::CAP_RESET;

    stack_scoreboard sb;
    int              burst_left = 0;
    int              stall_mode = 0;
    int              stall_cnt = 0;
    int              idle_cycles = 0;
    int unsigned     cap_plan [9] = '{1024, 2, 17, 0, 1023, 1, 2047, 64, 0};

    marked_stack_engine i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_func         (i_func),
        .i_data_in      (i_data_in),
        .i_mark_in      (i_mark_in),
        .i_offset       (i_offset),
        .i_slot_count   (i_slot_count),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_data_out     (o_data_out),
        .o_mark_out     (o_mark_out),
        .o_empty_res    (o_empty_res),
        .o_full_res     (o_full_res),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (stall_cnt == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_cnt = $urandom_range(20, 150);
        end else begin
            stall_cnt--;
        end
        case (stall_mode)
            0: i_out_ready = 1'b1;
            1: i_out_ready = 1'($urandom_range(0, 1));
            default: i_out_ready = ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.set_capacity(i_cfg_capacity);
            end
            if (i_in_valid && o_in_ready) begin
                sb.note_op(i_func, i_data_in, i_mark_in, i_offset, i_slot_count);
            end
            if (o_out_valid && i_out_ready) begin
                sb.check_result('{o_data_out, o_mark_out, o_empty_res, o_full_res, o_status});
            end
            if ((i_cfg_valid && o_cfg_ready) || (i_in_valid && o_in_ready)
                    || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("marked_stack_engine verification failed");
                $finish;
            end
        end
    end

    task automatic do_op(input logic [msk_pkg::FUNC_W-1:0] fn,
                         input logic [msk_pkg::WORD_W-1:0] data,
                         input logic [msk_pkg::MARK_W-1:0] mark,
                         input logic signed [msk_pkg::OFF_W-1:0] off,
                         input logic [msk_pkg::SLOT_W-1:0] slots);
        i_func = fn;
        i_data_in = data;
        i_mark_in = mark;
        i_offset = off;
        i_slot_count = slots;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        if (burst_left == 0) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(0, 15);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.results_due.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_capacity(input int unsigned value);
        wait_idle();
        i_cfg_capacity = msk_pkg::CAP_W'(value);
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_op();
        int unsigned                      sel;
        int unsigned                      depth;
        int                               target;
        logic [msk_pkg::FUNC_W-1:0]       fn;
        logic [msk_pkg::MARK_W-1:0]       mk;
        logic signed [msk_pkg::OFF_W-1:0] off;
        logic [msk_pkg::SLOT_W-1:0]       slots;
        depth = sb.fill;
        sel = $urandom_range(0, 99);
        if (sel < 34) fn = msk_pkg::FN_PUSH;
        else if (sel < 46) fn = msk_pkg::FN_POP;
        else if (sel < 52) fn = msk_pkg::FN_PEEK;
        else if (sel < 67) fn = msk_pkg::FN_GET;
        else if (sel < 81) fn = msk_pkg::FN_CHANGE;
        else if (sel < 90) fn = msk_pkg::FN_GRAB;
        else if (sel < 97) fn = msk_pkg::FN_CLR_MARK;
        else fn = msk_pkg::FN_CLEAR;
        if (depth > 0 && $urandom_range(0, 9) < 8) begin
            mk = msk_pkg::MARK_W'($urandom_range(0, depth - 1));
            target = $urandom_range(0, depth - 1);
            off = msk_pkg::OFF_W'(target - int'(mk));
        end else begin
            mk = msk_pkg::MARK_W'($urandom);
            off = msk_pkg::OFF_W'($urandom);
        end
        slots = ($urandom_range(0, 9) == 0) ? msk_pkg::SLOT_W'($urandom_range(0, 1024))
                                            : msk_pkg::SLOT_W'($urandom_range(0, 6));
        do_op(fn, $urandom, mk, off, slots);
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        do_op(msk_pkg::FN_POP, '0, '0, '0, '0);
        do_op(msk_pkg::FN_PEEK, '0, '0, '0, '0);
        do_op(msk_pkg::FN_GET, '0, '0, '0, '0);
        do_op(msk_pkg::FN_CLR_MARK, '0, '0, '0, '0);
        do_op(msk_pkg::FN_GRAB, '0, '0, '0, '0);
        do_op(msk_pkg::FN_GRAB, '0, '0, '0, 11'd1024);
        do_op(msk_pkg::FN_PUSH, 32'hFFFF_FFFF, '1, '1, '1);
        do_op(msk_pkg::FN_PUSH, 32'h0000_0000, '0, '0, '0);
        do_op(msk_pkg::FN_PUSH, 32'hA5A5_A5A5, '0, '0, '0);
        do_op(msk_pkg::FN_PEEK, '0, '0, '0, '0);
        do_op(msk_pkg::FN_GET, '0, 10'd0, 11'sd2, '0);
        do_op(msk_pkg::FN_GET, '0, 10'd2, -11'sd2, '0);
        do_op(msk_pkg::FN_GET, '0, 10'd1, -11'sd1024, '0);
        do_op(msk_pkg::FN_GET, '0, 10'd1, 11'sd1023, '0);
        do_op(msk_pkg::FN_GET, '0, 10'd1023, 11'sd0, '0);
        do_op(msk_pkg::FN_CHANGE, 32'h5A5A_5A5A, 10'd1, 11'sd0, '0);
        do_op(msk_pkg::FN_CHANGE, 32'h1234_5678, 10'd2, 11'sd1, '0);
        do_op(msk_pkg::FN_GET, '0, 10'd2, -11'sd1, '0);
        do_op(msk_pkg::FN_GRAB, '0, '0, '0, 11'd5);
        do_op(msk_pkg::FN_GET, '0, 10'd7, 11'sd0, '0);
        do_op(msk_pkg::FN_POP, '0, '0, '0, '0);
        do_op(msk_pkg::FN_CLR_MARK, '0, 10'd1, '0, '0);
        do_op(msk_pkg::FN_CLR_MARK, '0, 10'd5, '0, '0);
        do_op(msk_pkg::FN_CLEAR, '0, '0, '0, '0);

        write_capacity(3);
        repeat (4) do_op(msk_pkg::FN_PUSH, $urandom, '0, '0, '0);
        do_op(msk_pkg::FN_GRAB, '0, '0, '0, '0);
        write_capacity(1);
        do_op(msk_pkg::FN_PUSH, $urandom, '0, '0, '0);
        do_op(msk_pkg::FN_POP, '0, '0, '0, '0);
        do_op(msk_pkg::FN_CLEAR, '0, '0, '0, '0);
        write_capacity(0);
        do_op(msk_pkg::FN_PUSH, $urandom, '0, '0, '0);
        do_op(msk_pkg::FN_GRAB, '0, '0, '0, '0);
        write_capacity(2047);
        do_op(msk_pkg::FN_GRAB, '0, '0, '0, 11'd1023);
        do_op(msk_pkg::FN_PUSH, 32'hDEAD_BEEF, '0, '0, '0);
        do_op(msk_pkg::FN_PUSH, $urandom, '0, '0, '0);
        do_op(msk_pkg::FN_CHANGE, 32'hC0FF_EE00, 10'd0, 11'sd1023, '0);
        do_op(msk_pkg::FN_GET, '0, 10'd1023, -11'sd1023, '0);
        do_op(msk_pkg::FN_POP, '0, '0, '0, '0);
        do_op(msk_pkg::FN_CLEAR, '0, '0, '0, '0);

        cap_plan[8] = $urandom_range(1, 1024);
        foreach (cap_plan[p]) begin
            write_capacity(cap_plan[p]);
            repeat ((cap_plan[p] == 0) ? 20 : 160) random_op();
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.results_due.size() == 0) begin
            $display("marked_stack_engine verification clean");
        end else begin
            $display("marked_stack_engine verification failed");
        end
        $finish;
    end

endmodule
